// File: src/aus_pkg.sv
`default_nettype none
package aus_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_STRIP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'd1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  // Raw bytes of one input item's output, before upper casing; n is 1..3.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
  } run_t;

  // Code points U+00C0..U+017F.
  localparam logic [8*192-1:0] MAP_LO = {
    "AAAAAA1CEEEEIIII", "DNOOOOO.OUUUUY.s",
    "aaaaaa2ceeeeiiii", ".nooooo.ouuuuy.y",
    "AaAaAaCcCcCcCcDd", "DdEeEeEeEeEeGgGg",
    "GgGgHhHhIiIiIiIi", "Ii34JjKk.LlLlLlL",
    "lLlNnNnNnn..OoOo", "Oo56RrRrRrSsSsSs",
    "SsTtTtTtUuUuUuUu", "UuUuWwYyYZzZzZzs"
  };

  // Code points U+0180..U+01FF.
  localparam logic [8*128-1:0] MAP_HI = {
    "................", "..f.............",
    "Oo.............U", "u...............",
    ".............AaI", "iOoUuUuUuUuUu...",
    "................", "..........Aa12Oo"
  };

  // Offset from U+00C0, 0..319.
  function automatic logic [7:0] latin_code(input logic [8:0] ofs);
    logic [8:0] hi_ofs;
    hi_ofs = ofs - 9'd192;
    if (ofs < 9'd192) begin
      latin_code = MAP_LO[8*(191 - ofs[7:0]) +: 8];
    end else begin
      latin_code = MAP_HI[8*(127 - hi_ofs[6:0]) +: 8];
    end
  endfunction

endpackage
`default_nettype wire

// File: src/aus_front.sv
`default_nettype none
module aus_front import aus_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire in_t  data,
  input  wire logic strip_enable,
  output run_t      run,
  output logic      run_valid
);

  logic [7:0] p0, p1, p0_next, p1_next;
  logic [1:0] pc, pc_next;

  logic [7:0]  b;
  logic        cont, lead, need3, complete, hit;
  logic [1:0]  c, n, rn;
  logic [2:0][7:0] r;
  logic [15:0] cp;
  logic [7:0]  code, rep0, rep1;
  logic [8:0]  ofs;

  // Replacement lookup for a complete sequence.
  always_comb begin
    b     = data.text_byte;
    need3 = (p0 >= 8'hE0);
    cp    = need3 ? {p0[3:0], p1[5:0], b[5:0]} : {5'd0, p0[4:0], b[5:0]};
    ofs   = cp[8:0] - 9'h0C0;
    code  = latin_code(ofs);
    hit   = 1'b1;
    rn    = 2'd1;
    rep0  = code;
    rep1  = 8'h00;
    if (cp == 16'h1EBC) begin
      rep0 = "E";
    end else if (cp == 16'h1EBD) begin
      rep0 = "e";
    end else if (cp < 16'h00C0 || cp > 16'h01FF) begin
      hit = 1'b0;
    end else begin
      case (code)
        ".": hit = 1'b0;
        "1": begin rep0 = "A"; rep1 = "E"; rn = 2'd2; end
        "2": begin rep0 = "a"; rep1 = "e"; rn = 2'd2; end
        "3": begin rep0 = "I"; rep1 = "J"; rn = 2'd2; end
        "4": begin rep0 = "i"; rep1 = "j"; rn = 2'd2; end
        "5": begin rep0 = "O"; rep1 = "E"; rn = 2'd2; end
        "6": begin rep0 = "o"; rep1 = "e"; rn = 2'd2; end
        default: ;
      endcase
    end
  end

  always_comb begin
    cont     = (b[7:6] == 2'b10);
    lead     = (b >= 8'hC0) && (b <= 8'hEF);
    c        = (pc == 2'd3) ? 2'd2 : pc;
    complete = need3 ? (c == 2'd2) : 1'b1;
    p0_next  = p0;
    p1_next  = p1;
    pc_next  = pc;
    r        = '0;
    n        = 2'd0;
    if (pc != 2'd0 && cont) begin
      if (complete) begin
        if (strip_enable && hit) begin
          r[0] = rep0;
          r[1] = rep1;
          n    = rn;
        end else begin
          r[0] = p0;
          n    = 2'd1;
          if (c == 2'd2) begin
            r[1] = p1;
            n    = 2'd2;
          end
          r[n] = b;
          n    = n + 2'd1;
        end
        pc_next = 2'd0;
      end else begin
        p1_next = b;
        pc_next = 2'd2;
      end
    end else begin
      // Flush a broken sequence, then treat the byte as fresh.
      if (pc != 2'd0) begin
        r[0] = p0;
        n    = 2'd1;
        if (c == 2'd2) begin
          r[1] = p1;
          n    = 2'd2;
        end
      end
      pc_next = 2'd0;
      if (lead) begin
        p0_next = b;
        pc_next = 2'd1;
      end else begin
        r[n] = b;
        n    = n + 2'd1;
      end
    end
    if (data.end_of_text) begin
      if (pc_next != 2'd0 && n != 2'd3) begin
        r[n] = p0_next;
        n    = n + 2'd1;
      end
      if (pc_next[1] && n != 2'd3) begin
        r[n] = p1_next;
        n    = n + 2'd1;
      end
      pc_next = 2'd0;
    end
    run.bytes = r;
    run.n     = n;
    run_valid = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 2'd0;
      p0 <= 8'h00;
      p1 <= 8'h00;
    end else if (accept) begin
      pc <= pc_next;
      p0 <= p0_next;
      p1 <= p1_next;
    end
  end

endmodule
`default_nettype wire

// File: src/aus_queue.sv
`default_nettype none
module aus_queue import aus_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire run_t wr_run,
  input  wire logic pop,
  output run_t      head,
  output logic      empty,
  output logic      full
);

  localparam int PW = $clog2(DEPTH);

  run_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (PW+1)'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/aus_back.sv
`default_nettype none
module aus_back import aus_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire run_t head,
  input  wire logic empty,
  input  wire logic upper_enable,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic [1:0] k;
  logic       load, take, last;
  logic [7:0] bsel, bcase;

  always_comb begin
    load  = !out_valid || !out_stall;
    take  = load && !empty;
    last  = (k == head.n - 2'd1);
    pop   = take && last;
    bsel  = head.bytes[k];
    bcase = bsel;
    if (upper_enable && bsel >= "a" && bsel <= "z") begin
      bcase = bsel - 8'h20;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= take;
      if (take) begin
        k <= last ? 2'd0 : k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.out_byte    <= bcase;
      out_data.last_of_run <= last;
    end
  end

endmodule
`default_nettype wire

// File: src/utf8_accent_strip_upper_unit.sv
// channel | handshake              | payload
// in      | in_valid / in_stall    | in_data  (text_byte, end_of_text)
// out     | out_valid / out_stall  | out_data (out_byte, last_of_run)
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One input byte is taken per cycle; in_stall rises while the run queue is
// full and no byte is taken then. Any results go into the queue, and the
// output register sends one byte per cycle while out_stall is low, so an
// item with k results holds the back end until all k are sent.
// Reset clears held bytes, the queue and sets both enables.
`default_nettype none
module utf8_accent_strip_upper_unit import aus_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data
);

  logic strip_enable, upper_enable;
  logic accept, push, pop, empty, full;
  run_t run, head;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_enable <= 1'b1;
      upper_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STRIP: strip_enable <= cfg_data;
        REG_UPPER: upper_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  aus_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data         (in_data),
    .strip_enable (strip_enable),
    .run          (run),
    .run_valid    (push)
  );

  aus_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_run (run),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  aus_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .upper_enable (upper_enable),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
`default_nettype wire

// File: tb/utf8_accent_strip_upper_unit_tb.sv
`default_nettype none
module utf8_accent_strip_upper_unit_tb import aus_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic cfg_data = 1'b0;

  utf8_accent_strip_upper_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Latin letters U+00C0..U+01FF; digits code ligatures, '.' has no entry.
  localparam string LATIN =
    {"AAAAAA1CEEEEIIIIDNOOOOO.OUUUUY.saaaaaa2ceeeeiiii.nooooo.ouuuuy.y",
     "AaAaAaCcCcCcCcDdDdEeEeEeEeEeGgGgGgGgHhHhIiIiIiIiIi34JjKk.LlLlLlL",
     "lLlNnNnNnn..OoOoOo56RrRrRrSsSsSsSsTtTtTtUuUuUuUuUuUuWwYyYZzZzZzs",
     "..................f.............Oo.............Uu...............",
     ".............AaIiOoUuUuUuUuUu.............................Aa12Oo"};

  in_t text_queue[$];
  out_t expected_bytes[$];
  int errors = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  bit in_held = 1'b0;

  logic strip_on, upper_on;
  logic [7:0] held_bytes[2];
  int held_n;
  logic [7:0] run_bytes[$];

  function automatic void put_byte(logic [7:0] b);
    if (run_bytes.size() >= 3) return;
    if (upper_on && b >= 8'h61 && b <= 8'h7A) b = b - 8'h20;
    run_bytes.push_back(b);
  endfunction

  function automatic void release_held();
    for (int k = 0; k < held_n; k++) put_byte(held_bytes[k]);
    held_n = 0;
  endfunction

  function automatic bit transliterate(logic [15:0] cp);
    byte m;
    if (cp == 16'h1EBC) begin put_byte("E"); return 1; end
    if (cp == 16'h1EBD) begin put_byte("e"); return 1; end
    if (cp < 16'h00C0 || cp > 16'h01FF) return 0;
    m = LATIN[cp - 16'h00C0];
    case (m)
      ".": return 0;
      "1": begin put_byte("A"); put_byte("E"); end
      "2": begin put_byte("a"); put_byte("e"); end
      "3": begin put_byte("I"); put_byte("J"); end
      "4": begin put_byte("i"); put_byte("j"); end
      "5": begin put_byte("O"); put_byte("E"); end
      "6": begin put_byte("o"); put_byte("e"); end
      default: put_byte(m);
    endcase
    return 1;
  endfunction

  function automatic void convert_byte(in_t it);
    logic [7:0] b;
    bit fresh;
    int need;
    logic [15:0] cp;
    out_t o;
    b = it.text_byte;
    fresh = 1;
    run_bytes.delete();
    if (held_n != 0) begin
      if (b[7:6] == 2'b10) begin
        fresh = 0;
        need = (held_bytes[0] >= 8'hE0) ? 3 : 2;
        if (held_n + 1 >= need) begin
          if (need == 2) cp = {5'd0, held_bytes[0][4:0], b[5:0]};
          else cp = {held_bytes[0][3:0], held_bytes[1][5:0], b[5:0]};
          if (!(strip_on && transliterate(cp))) begin
            release_held();
            put_byte(b);
          end
          held_n = 0;
        end else begin
          held_bytes[held_n] = b;
          held_n++;
        end
      end else begin
        release_held();
      end
    end
    if (fresh) begin
      if (b >= 8'hC0 && b <= 8'hEF) begin
        held_bytes[0] = b;
        held_n = 1;
      end else begin
        put_byte(b);
      end
    end
    if (it.end_of_text) release_held();
    foreach (run_bytes[k]) begin
      o.out_byte = run_bytes[k];
      o.last_of_run = (k == run_bytes.size() - 1);
      expected_bytes.push_back(o);
    end
  endfunction

  // Driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_held) begin
      // hold
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (text_queue.size() > 0) begin
      in_data <= text_queue.pop_front();
      in_valid <= 1'b1;
      in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_held <= !rst && in_valid && in_stall;
    if (!rst && in_valid && !in_stall) begin
      convert_byte(in_data);
      items_sent++;
    end
  end

  // Monitor
  int stall_left = 0;
  bit stall_burst = 1'b1;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (stall_burst) stall_left <= $urandom_range(0, 4);
      if ($urandom_range(0, 40) == 0) stall_burst <= ~stall_burst;
    end
  end

  always @(posedge clk) begin
    out_t exp_o;
    if (!rst && out_valid && !out_stall) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected item: out_byte %h last_of_run %b",
               out_data.out_byte, out_data.last_of_run);
        errors++;
      end else begin
        exp_o = expected_bytes.pop_front();
        if (exp_o.out_byte !== out_data.out_byte) begin
          $error("out_byte: expected %h, actual %h", exp_o.out_byte, out_data.out_byte);
          errors++;
        end
        if (exp_o.last_of_run !== out_data.last_of_run) begin
          $error("last_of_run: expected %b, actual %b",
                 exp_o.last_of_run, out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_STRIP) strip_on = val;
    else upper_on = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (text_queue.size() > 0 || in_valid || expected_bytes.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void add(logic [7:0] b, logic eot = 1'b0);
    in_t it;
    it.text_byte = b;
    it.end_of_text = eot;
    text_queue.push_back(it);
  endfunction

  function automatic void add_letter(logic [15:0] cp);
    if (cp < 16'h0800) begin
      add({3'b110, cp[10:6]});
      add({2'b10, cp[5:0]});
    end else begin
      add({4'b1110, cp[15:12]});
      add({2'b10, cp[11:6]});
      add({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void add_random_text(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r < 4) add_letter(16'($urandom_range(16'h00C0, 16'h01FF)));
      else if (r == 4) add_letter($urandom_range(0, 1) ? 16'h1EBC : 16'h1EBD);
      else if (r == 5) add_letter(16'($urandom_range(16'h0080, 16'hFFFF)));
      else if (r < 8) add(8'($urandom_range(8'h20, 8'h7E)));
      else add(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endfunction

  initial begin
    strip_on = 1'b1;
    upper_on = 1'b1;
    held_n = 0;
    held_bytes[0] = '0;
    held_bytes[1] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: ascii extremes, ligatures, unmapped, strays, broken and flushed sequences
    add(8'h00); add(8'h61); add(8'h7A); add(8'hFF); add(8'hF0); add(8'h80);
    add_letter(16'h00C6); add_letter(16'h0132); add_letter(16'h0153);
    add_letter(16'h00DF); add_letter(16'h017F); add_letter(16'h0141);
    add_letter(16'h00D7); add_letter(16'h1EBD);
    add(8'hC3); add(8'h41);
    add(8'hE1); add(8'hBA); add(8'h7A);
    add(8'hC3, 1'b1);
    add(8'hE1); add(8'hBA, 1'b1);
    add(8'hDF); add(8'hBF); add(8'hEF); add(8'hBF); add(8'hBF);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_STRIP, ph[0]);
      write_reg(REG_UPPER, ph[1]);
      add_random_text(30);
      drain();
    end
    write_reg(REG_STRIP, 1'b1);
    write_reg(REG_UPPER, 1'b1);
    add_random_text(20);
    drain();

    $display("covered %0d input items and %0d output bytes over four enable settings",
             items_sent, bytes_checked);
    if (errors == 0) $display("utf8_accent_strip_upper_unit_tb: done, clean");
    else $display("utf8_accent_strip_upper_unit_tb: done, errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("utf8_accent_strip_upper_unit_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
